@@ rtl/core/golden_ratio_hsv_color_generator_top_macros.svh @@
// assertion macros for the golden-ratio color generator checker
// expects i_clk and i_rst_n in the scope of use
`ifndef GOLDEN_RATIO_HSV_COLOR_GENERATOR_TOP_MACROS_SVH
`define GOLDEN_RATIO_HSV_COLOR_GENERATOR_TOP_MACROS_SVH

// checked only out of reset
`define GRHSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in and out of reset
`define GRHSV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/grhsv_pkg.sv @@
// shared types, constants and rounding multiply for the color generator
// no dependencies
package grhsv_pkg;

    localparam logic [15:0] GOLDEN_STEP = 16'd40503;
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [16:0] VAL_Q16     = 17'd62259;
    localparam logic [16:0] SAT_LIGHT   = 17'd32768;
    localparam logic [16:0] SAT_DARK    = 17'd58982;
    localparam logic [16:0] BYTE_SCALE  = 17'd255;
    localparam logic [33:0] HALF_Q16    = 34'd32768;

    // rnd(a * b) in q0.16, result always below 65536 for the operands used here
    function automatic logic [15:0] mul_rnd(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] prod;
        prod = 34'(a * b) + HALF_Q16;
        return prod[31:16];
    endfunction

    localparam logic [15:0] P_LIGHT = mul_rnd(VAL_Q16, ONE_Q16 - SAT_LIGHT);
    localparam logic [15:0] P_DARK  = mul_rnd(VAL_Q16, ONE_Q16 - SAT_DARK);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SECT,
        ST_SF,
        ST_SNF,
        ST_Q,
        ST_T,
        ST_BR,
        ST_BG,
        ST_BB,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SECT,
        OP_SF,
        OP_SNF,
        OP_Q,
        OP_T,
        OP_BR,
        OP_BG,
        OP_BB
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/grhsv_in_if.sv @@
// request channel: valid, ready and palette choice
// no dependencies
interface grhsv_in_if;
    logic valid;
    logic ready;
    logic palette_dark;

    modport source (output valid, output palette_dark, input ready);
    modport sink (input valid, input palette_dark, output ready);
endinterface

@@ rtl/core/grhsv_out_if.sv @@
// color channel: valid, ready and 8-bit rgb
// no dependencies
interface grhsv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/core/grhsv_ctrl.sv @@
// sequencer for one color: hue sector, products, byte rounding, hand-off
// depends on grhsv_pkg
module grhsv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  grhsv_pkg::t_status i_status,
    output grhsv_pkg::t_cmd    o_cmd
);

    grhsv_pkg::t_state r_state;
    grhsv_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grhsv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            grhsv_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = grhsv_pkg::ST_SECT;
                end
            end
            grhsv_pkg::ST_SECT: n_state = grhsv_pkg::ST_SF;
            grhsv_pkg::ST_SF:   n_state = grhsv_pkg::ST_SNF;
            grhsv_pkg::ST_SNF:  n_state = grhsv_pkg::ST_Q;
            grhsv_pkg::ST_Q:    n_state = grhsv_pkg::ST_T;
            grhsv_pkg::ST_T:    n_state = grhsv_pkg::ST_BR;
            grhsv_pkg::ST_BR:   n_state = grhsv_pkg::ST_BG;
            grhsv_pkg::ST_BG:   n_state = grhsv_pkg::ST_BB;
            grhsv_pkg::ST_BB:   n_state = grhsv_pkg::ST_DONE;
            grhsv_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = grhsv_pkg::ST_IDLE;
                end
            end
            default: n_state = grhsv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.op       = grhsv_pkg::OP_NONE;
        o_cmd.take     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            grhsv_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            grhsv_pkg::ST_SECT: o_cmd.op = grhsv_pkg::OP_SECT;
            grhsv_pkg::ST_SF:   o_cmd.op = grhsv_pkg::OP_SF;
            grhsv_pkg::ST_SNF:  o_cmd.op = grhsv_pkg::OP_SNF;
            grhsv_pkg::ST_Q:    o_cmd.op = grhsv_pkg::OP_Q;
            grhsv_pkg::ST_T:    o_cmd.op = grhsv_pkg::OP_T;
            grhsv_pkg::ST_BR:   o_cmd.op = grhsv_pkg::OP_BR;
            grhsv_pkg::ST_BG:   o_cmd.op = grhsv_pkg::OP_BG;
            grhsv_pkg::ST_BB:   o_cmd.op = grhsv_pkg::OP_BB;
            grhsv_pkg::ST_DONE: o_cmd.load_out = i_status.out_free;
            default: o_cmd.op = grhsv_pkg::OP_NONE;
        endcase
    end

endmodule

@@ rtl/core/grhsv_dp.sv @@
// datapath: hue accumulator, sector split, shared rounding multiplier, output register
// depends on grhsv_pkg
module grhsv_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_palette_dark,
    input  grhsv_pkg::t_cmd    i_cmd,
    output grhsv_pkg::t_status o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    logic [15:0] r_phase;
    logic        r_out_valid;
    logic        r_dark;
    logic [2:0]  r_sector;
    logic [15:0] r_ff;
    logic [15:0] r_m1;
    logic [15:0] r_m2;
    logic [15:0] r_q;
    logic [15:0] r_t;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;

    logic [18:0] w_h6;
    logic [16:0] w_sat;
    logic [15:0] w_p;
    logic [15:0] w_rch;
    logic [15:0] w_gch;
    logic [15:0] w_bch;
    logic [16:0] w_opa;
    logic [16:0] w_opb;
    logic [15:0] w_res;

    // hue times six: sector in the integer part, fraction below
    assign w_h6  = {1'b0, r_phase, 2'b00} + {2'b00, r_phase, 1'b0};
    assign w_sat = r_dark ? grhsv_pkg::SAT_DARK : grhsv_pkg::SAT_LIGHT;
    assign w_p   = r_dark ? grhsv_pkg::P_DARK : grhsv_pkg::P_LIGHT;

    always_comb begin
        unique case (r_sector)
            3'd0: begin
                w_rch = grhsv_pkg::VAL_Q16[15:0];
                w_gch = r_t;
                w_bch = w_p;
            end
            3'd1: begin
                w_rch = r_q;
                w_gch = grhsv_pkg::VAL_Q16[15:0];
                w_bch = w_p;
            end
            3'd2: begin
                w_rch = w_p;
                w_gch = grhsv_pkg::VAL_Q16[15:0];
                w_bch = r_t;
            end
            3'd3: begin
                w_rch = w_p;
                w_gch = r_q;
                w_bch = grhsv_pkg::VAL_Q16[15:0];
            end
            3'd4: begin
                w_rch = r_t;
                w_gch = w_p;
                w_bch = grhsv_pkg::VAL_Q16[15:0];
            end
            default: begin
                w_rch = grhsv_pkg::VAL_Q16[15:0];
                w_gch = w_p;
                w_bch = r_q;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.op)
            grhsv_pkg::OP_SF: begin
                w_opa = w_sat;
                w_opb = {1'b0, r_ff};
            end
            grhsv_pkg::OP_SNF: begin
                w_opa = w_sat;
                w_opb = grhsv_pkg::ONE_Q16 - {1'b0, r_ff};
            end
            grhsv_pkg::OP_Q: begin
                w_opa = grhsv_pkg::VAL_Q16;
                w_opb = grhsv_pkg::ONE_Q16 - {1'b0, r_m1};
            end
            grhsv_pkg::OP_T: begin
                w_opa = grhsv_pkg::VAL_Q16;
                w_opb = grhsv_pkg::ONE_Q16 - {1'b0, r_m2};
            end
            grhsv_pkg::OP_BR: begin
                w_opa = grhsv_pkg::BYTE_SCALE;
                w_opb = {1'b0, w_rch};
            end
            grhsv_pkg::OP_BG: begin
                w_opa = grhsv_pkg::BYTE_SCALE;
                w_opb = {1'b0, w_gch};
            end
            grhsv_pkg::OP_BB: begin
                w_opa = grhsv_pkg::BYTE_SCALE;
                w_opb = {1'b0, w_bch};
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_res = grhsv_pkg::mul_rnd(w_opa, w_opb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase <= i_cfg_data;
            end else if (i_cmd.take) begin
                r_phase <= r_phase + grhsv_pkg::GOLDEN_STEP;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dark <= i_palette_dark;
        end
        if (i_cmd.load_out) begin
            r_out_red   <= r_red;
            r_out_green <= r_green;
            r_out_blue  <= r_blue;
        end
        unique case (i_cmd.op)
            grhsv_pkg::OP_SECT: begin
                r_sector <= w_h6[18:16];
                r_ff     <= w_h6[15:0];
            end
            grhsv_pkg::OP_SF:  r_m1    <= w_res;
            grhsv_pkg::OP_SNF: r_m2    <= w_res;
            grhsv_pkg::OP_Q:   r_q     <= w_res;
            grhsv_pkg::OP_T:   r_t     <= w_res;
            grhsv_pkg::OP_BR:  r_red   <= w_res[7:0];
            grhsv_pkg::OP_BG:  r_green <= w_res[7:0];
            grhsv_pkg::OP_BB:  r_blue  <= w_res[7:0];
            default: ;
        endcase
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_red             = r_out_red;
    assign o_green           = r_out_green;
    assign o_blue            = r_out_blue;

endmodule

@@ rtl/core/golden_ratio_hsv_color_generator_top.sv @@
// Golden-ratio plot color generator. Each request beat advances a 16-bit hue phase by
// 40503/65536 and returns the HSV-to-RGB color of the new hue with value 0.95 and
// saturation 0.5 (light) or 0.9 (dark), each channel rounded to 8 bits. Writing the seed
// register loads the hue phase, so the next color starts one step past the seed; reset
// clears the phase to zero. A request steps through the states SECT, SF, SNF, Q, T, BR,
// BG, BB and DONE; the result beat shows once DONE finds the output register free and
// loads it, and the controller goes back to IDLE for the next request; one finished
// color may wait in the output register while the next is computed. A single shared
// 17x17 rounding multiplier is stepped through seven products per color by the controller.
// depends on grhsv_pkg, grhsv_in_if, grhsv_out_if, grhsv_ctrl, grhsv_dp
module golden_ratio_hsv_color_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    grhsv_in_if.sink    i_in,
    grhsv_out_if.source o_out
);

    grhsv_pkg::t_cmd    w_cmd;
    grhsv_pkg::t_status w_status;

    grhsv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    grhsv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_palette_dark (i_in.palette_dark),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_red          (o_out.red),
        .o_green        (o_out.green),
        .o_blue         (o_out.blue)
    );

endmodule

@@ rtl/core/grhsv_checker.sv @@
// port-level checks for the color generator, bound to the top level
// depends on golden_ratio_hsv_color_generator_top_macros.svh
`include "golden_ratio_hsv_color_generator_top_macros.svh"

module grhsv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    logic w_in_beat;

    assign w_in_beat = i_in_valid && i_in_ready;

    `GRHSV_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !i_out_valid, "out valid after reset")
    `GRHSV_ASSERT(a_out_valid_holds, i_out_valid && !i_out_ready |=> i_out_valid, "out valid dropped")
    `GRHSV_ASSERT(a_busy_after_take, w_in_beat |=> !i_in_ready, "ready right after request")
    `GRHSV_ASSERT(a_no_instant_result, w_in_beat |=> !$rose(i_out_valid), "result too early")

endmodule

bind golden_ratio_hsv_color_generator_top grhsv_checker u_grhsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

@@ sim/testbench.sv @@
// self-checking testbench for golden_ratio_hsv_color_generator_top: random request and color
// handshakes, seed writes between phases, every color checked against a hue-phase predictor
// depends on grhsv_in_if, grhsv_out_if and the rtl of the color generator
`timescale 1ns / 100ps

module testbench;

    localparam int          CLK_PERIOD  = 20;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          IDLE_PCT    = 8;
    localparam int          MAX_REPORTS = 10;
    localparam int          RUN_PHASES  = 8;
    localparam int          PHASE_BEATS = 137;
    localparam int          SETTLE      = 24;

    localparam logic [15:0] HUE_STEP    = 16'd40503;
    localparam logic [16:0] Q16_ONE     = 17'h10000;
    localparam logic [16:0] V_LEVEL     = 17'd62259;
    localparam logic [16:0] SAT_LIGHT_Q = 17'd32768;
    localparam logic [16:0] SAT_DARK_Q  = 17'd58982;
    localparam logic        PALETTE_LIGHT = 1'b0;
    localparam logic        PALETTE_DARK  = 1'b1;

    typedef enum logic [2:0] {
        HUE_RED_YELLOW,
        HUE_YELLOW_GREEN,
        HUE_GREEN_CYAN,
        HUE_CYAN_BLUE,
        HUE_BLUE_MAGENTA,
        HUE_MAGENTA_RED
    } t_hue_sector;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    grhsv_in_if  req_if ();
    grhsv_out_if color_if ();

    golden_ratio_hsv_color_generator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (req_if),
        .o_out      (color_if)
    );

    logic   palette_queue [$];
    t_color expected_colors [$];
    logic [15:0] hue_phase;
    logic   no_idle;
    int     cycle_count;
    int     colors_checked;
    int     mismatch_count;
    int     seed_writes;
    int     dark_requests;
    int     light_requests;

    function automatic logic [16:0] q16_mul(input logic [16:0] a, input logic [16:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b) + 64'd32768;
        return prod[32:16];
    endfunction

    function automatic logic [7:0] to_channel(input logic [16:0] x);
        logic [31:0] scaled;
        scaled = 32'(x) * 32'd255 + 32'd32768;
        return scaled[23:16];
    endfunction

    function automatic t_color hsv_color(input logic [15:0] hue, input logic dark);
        logic [18:0]  hue6;
        logic [16:0]  frac;
        logic [16:0]  sat;
        logic [16:0]  p;
        logic [16:0]  q;
        logic [16:0]  t;
        logic [16:0]  r;
        logic [16:0]  g;
        logic [16:0]  b;
        t_hue_sector  sector;
        t_color       c;
        hue6   = 19'(hue) * 19'd6;
        frac   = {1'b0, hue6[15:0]};
        sector = t_hue_sector'(hue6[18:16]);
        sat    = dark ? SAT_DARK_Q : SAT_LIGHT_Q;
        p = q16_mul(V_LEVEL, Q16_ONE - sat);
        q = q16_mul(V_LEVEL, Q16_ONE - q16_mul(sat, frac));
        t = q16_mul(V_LEVEL, Q16_ONE - q16_mul(sat, Q16_ONE - frac));
        case (sector)
            HUE_RED_YELLOW: begin
                r = V_LEVEL; g = t; b = p;
            end
            HUE_YELLOW_GREEN: begin
                r = q; g = V_LEVEL; b = p;
            end
            HUE_GREEN_CYAN: begin
                r = p; g = V_LEVEL; b = t;
            end
            HUE_CYAN_BLUE: begin
                r = p; g = q; b = V_LEVEL;
            end
            HUE_BLUE_MAGENTA: begin
                r = t; g = p; b = V_LEVEL;
            end
            default: begin
                r = V_LEVEL; g = p; b = q;
            end
        endcase
        c.red   = to_channel(r);
        c.green = to_channel(g);
        c.blue  = to_channel(b);
        return c;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors still expected",
                     cycle_count, expected_colors.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid        <= 1'b0;
            req_if.palette_dark <= PALETTE_LIGHT;
        end else if (!req_if.valid || req_if.ready) begin
            if (palette_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                req_if.valid        <= 1'b1;
                req_if.palette_dark <= palette_queue.pop_front();
            end else begin
                req_if.valid        <= 1'b0;
                req_if.palette_dark <= 1'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            color_if.ready <= 1'b0;
        end else begin
            color_if.ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // predictor and color checker
    always @(posedge i_clk) begin : monitor
        t_color want;
        if (!i_rst_n) begin
            hue_phase = 16'd0;
            expected_colors.delete();
        end else begin
            if (cfg_we) begin
                hue_phase = cfg_data;
            end
            if (req_if.valid && req_if.ready) begin
                hue_phase = hue_phase + HUE_STEP;
                expected_colors.push_back(hsv_color(hue_phase, req_if.palette_dark));
                if (req_if.palette_dark == PALETTE_DARK) begin
                    dark_requests++;
                end else begin
                    light_requests++;
                end
            end
            if (color_if.valid && color_if.ready) begin
                colors_checked++;
                if (expected_colors.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("color beat %02h %02h %02h with no request pending",
                                 color_if.red, color_if.green, color_if.blue);
                    end
                end else begin
                    want = expected_colors.pop_front();
                    if (color_if.red !== want.red || color_if.green !== want.green ||
                        color_if.blue !== want.blue) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"color %0d mismatch: expected rgb %02h %02h %02h,",
                                      " got %02h %02h %02h"},
                                     colors_checked, want.red, want.green, want.blue,
                                     color_if.red, color_if.green, color_if.blue);
                        end
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (palette_queue.size() != 0 || req_if.valid || expected_colors.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_seed(input logic [15:0] seed);
        cfg_we   <= 1'b1;
        cfg_data <= seed;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        seed_writes++;
    endtask

    initial begin : stimulus
        logic [15:0] edge_hues [12];
        logic [15:0] seed;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = 16'd0;
        req_if.valid        = 1'b0;
        req_if.palette_dark = PALETTE_LIGHT;
        color_if.ready      = 1'b0;
        no_idle             = 1'b0;
        cycle_count         = 0;
        colors_checked      = 0;
        mismatch_count      = 0;
        seed_writes         = 0;
        dark_requests       = 0;
        light_requests      = 0;
        edge_hues = '{16'd0, 16'd65535, 16'd10922, 16'd10923, 16'd21845, 16'd21846,
                      16'd32767, 16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase starts from zero after reset
        palette_queue.push_back(PALETTE_LIGHT);
        palette_queue.push_back(PALETTE_DARK);
        palette_queue.push_back(PALETTE_LIGHT);
        palette_queue.push_back(PALETTE_DARK);
        wait_drained();

        // hue extremes and both sides of every sector boundary
        for (int i = 0; i < 12; i++) begin
            write_seed(edge_hues[i] - HUE_STEP);
            palette_queue.push_back(i[0] ? PALETTE_DARK : PALETTE_LIGHT);
            wait_drained();
        end

        write_seed(16'h0000);
        palette_queue.push_back(PALETTE_LIGHT);
        palette_queue.push_back(PALETTE_DARK);
        wait_drained();
        write_seed(16'hFFFF);
        palette_queue.push_back(PALETTE_DARK);
        palette_queue.push_back(PALETTE_LIGHT);
        wait_drained();

        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            if (ph == 0) begin
                seed = 16'h0000;
            end else if (ph == 1) begin
                seed = 16'hFFFF;
            end else begin
                seed = 16'($urandom);
            end
            write_seed(seed);
            no_idle = (ph == 3);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // hold the sender until every color is back
                if (ph == 5 && k == PHASE_BEATS / 2) begin
                    wait_drained();
                end
                palette_queue.push_back(1'($urandom_range(0, 1)));
            end
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (SETTLE) @(posedge i_clk);
        $display("checked %0d colors (%0d light, %0d dark requests) over %0d seed writes",
                 colors_checked, light_requests, dark_requests, seed_writes);
        $display("hue extremes, all sector boundaries and both palettes covered, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_colors.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ golden_ratio_hsv_color_generator_top.f @@
+incdir+rtl/core
rtl/core/grhsv_pkg.sv
rtl/core/grhsv_in_if.sv
rtl/core/grhsv_out_if.sv
rtl/core/grhsv_ctrl.sv
rtl/core/grhsv_dp.sv
rtl/core/golden_ratio_hsv_color_generator_top.sv
rtl/core/grhsv_checker.sv
sim/testbench.sv
